// ===== design/lasm_pkg.sv =====
// shared types, constants and the cordic arctangent table for the angular mask
// used by every module of lidar_angular_sector_mask
package lasm_pkg;

    localparam int MAX_SECTORS_DEF   = 2;
    localparam int COORD_WIDTH_DEF   = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 3;

    localparam int FULL_CIRCLE = 23040;
    localparam int ELEV_LIMIT  = 57600;
    localparam int RIGHT_ANGLE = 5760;
    localparam int GAIN_Q20    = 1726753;
    localparam int FRAC_SHIFT  = 20;

    localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEV_FLOOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ELEV_CEILING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR0_LO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR0_HI   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR1_LO   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR1_HI   = 3'd7;

    typedef enum logic [1:0] {
        REASON_KEEP   = 2'd0,
        REASON_BELOW  = 2'd1,
        REASON_ABOVE  = 2'd2,
        REASON_SECTOR = 2'd3
    } t_reason;

    typedef struct packed {
        logic origin;
        logic axis;
        logic zpos;
    } t_flags;

    typedef struct packed {
        logic               enable;
        logic               floor_on;
        logic               ceil_on;
        logic signed [16:0] floor_v;
        logic signed [16:0] ceil_v;
        logic [1:0]         sec_used;
        logic [1:0][14:0]   sec_lo;
        logic [1:0][14:0]   sec_hi;
    } t_cfg;

    function automatic logic [31:0] atan_turns(input int idx);
        logic [31:0] r;
        case (idx)
            0: r = 32'd536870912;   1: r = 32'd316933406;   2: r = 32'd167458907;
            3: r = 32'd85004756;    4: r = 32'd42667331;    5: r = 32'd21354465;
            6: r = 32'd10679838;    7: r = 32'd5340245;     8: r = 32'd2670163;
            9: r = 32'd1335087;     10: r = 32'd667544;     11: r = 32'd333772;
            12: r = 32'd166886;     13: r = 32'd83443;      14: r = 32'd41722;
            15: r = 32'd20861;      16: r = 32'd10430;      17: r = 32'd5215;
            18: r = 32'd2608;       19: r = 32'd1304;       20: r = 32'd652;
            21: r = 32'd326;        22: r = 32'd163;        23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // reduce a signed 16 bit angle into [0, FULL_CIRCLE)
    function automatic logic [14:0] norm_angle(input logic signed [15:0] v);
        logic signed [16:0] r;
        r = 17'(v);
        if (r < 0) r = r + 17'sd23040;
        if (r < 0) r = r + 17'sd23040;
        if (r >= 17'sd23040) r = r - 17'sd23040;
        return r[14:0];
    endfunction

endpackage

// ===== design/lasm_point_if.sv =====
// request channel carrying one lidar point
// depends on nothing
interface lasm_point_if #(parameter int COORD_WIDTH = 24);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

// ===== design/lasm_mask_if.sv =====
// request channel carrying the mask decision for one point
// depends on nothing
interface lasm_mask_if;
    logic       valid;
    logic       ready;
    logic       remove_point;
    logic [1:0] remove_reason;
    modport source (output valid, remove_point, remove_reason, input ready);
    modport sink (input valid, remove_point, remove_reason, output ready);
endinterface

// ===== design/lasm_cordic_cell.sv =====
// one vectoring cordic micro-rotation with its pipeline register
// uses lasm_pkg for the arctangent table
module lasm_cordic_cell #(
    parameter int W     = 48,
    parameter int SW    = 8,
    parameter int SHIFT = 0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic [31:0]         i_acc,
    input  logic [SW-1:0]       i_side,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic [31:0]         o_acc,
    output logic [SW-1:0]       o_side
);
    import lasm_pkg::*;

    localparam logic [31:0] ANGLE = atan_turns(SHIFT);

    logic signed [W-1:0] xs, ys, n_x, n_y;
    logic [31:0]         n_acc;
    logic signed [W-1:0] r_x, r_y;
    logic [31:0]         r_acc;
    logic [SW-1:0]       r_side;

    always_comb begin
        xs = i_x >>> SHIFT;
        ys = i_y >>> SHIFT;
        if (!i_y[W-1]) begin
            n_x   = i_x + ys;
            n_y   = i_y - xs;
            n_acc = i_acc + ANGLE;
        end else begin
            n_x   = i_x - ys;
            n_y   = i_y + xs;
            n_acc = i_acc - ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_acc  <= n_acc;
            r_side <= i_side;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_acc  = r_acc;
    assign o_side = r_side;
endmodule

// ===== design/lasm_decide.sv =====
// converts binary-turn angles to 1/64 degree and picks the removal reason
// uses lasm_pkg for config and reason types
module lasm_decide #(
    parameter int MAX_SECTORS = 2
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [31:0]       i_az_acc,
    input  logic [31:0]       i_el_acc,
    input  lasm_pkg::t_flags  i_flags,
    input  lasm_pkg::t_cfg    i_cfg,
    output logic              o_remove,
    output lasm_pkg::t_reason o_reason
);
    import lasm_pkg::*;

    logic [46:0]        az_prod;
    logic signed [47:0] el_prod;
    logic [14:0]        r_az;
    logic signed [15:0] r_el;
    t_flags             r_flags;

    logic [14:0]        az_w;
    logic signed [16:0] el_w;
    logic [1:0]         hit;
    t_reason            n_reason;
    t_reason            r_reason;

    always_comb begin
        az_prod = {15'd0, i_az_acc} * 47'd23040 + 47'h80000000;
        el_prod = 48'($signed(i_el_acc)) * 48'sd23040 + 48'sd2147483648;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_az    <= az_prod[46:32];
            r_el    <= el_prod[47:32];
            r_flags <= i_flags;
        end
    end

    always_comb begin
        if (r_flags.axis) begin
            az_w = '0;
            el_w = r_flags.zpos ? 17'sd5760 : -17'sd5760;
        end else begin
            az_w = (r_az >= 15'd23040) ? 15'd0 : r_az;
            el_w = 17'(r_el);
        end
        for (int k = 0; k < 2; k++) begin
            if (k < MAX_SECTORS && i_cfg.sec_used[k]) begin
                if (i_cfg.sec_lo[k] <= i_cfg.sec_hi[k])
                    hit[k] = az_w >= i_cfg.sec_lo[k] && az_w <= i_cfg.sec_hi[k];
                else
                    hit[k] = az_w >= i_cfg.sec_lo[k] || az_w <= i_cfg.sec_hi[k];
            end else begin
                hit[k] = 1'b0;
            end
        end
        priority if (!i_cfg.enable || r_flags.origin) begin
            n_reason = REASON_KEEP;
        end else if (i_cfg.floor_on && el_w < i_cfg.floor_v) begin
            n_reason = REASON_BELOW;
        end else if (i_cfg.ceil_on && el_w > i_cfg.ceil_v) begin
            n_reason = REASON_ABOVE;
        end else if (|hit) begin
            n_reason = REASON_SECTOR;
        end else begin
            n_reason = REASON_KEEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_reason <= n_reason;
    end

    assign o_reason = r_reason;
    assign o_remove = (r_reason != REASON_KEEP);
endmodule

// ===== design/lidar_angular_sector_mask.sv =====
// angular sector mask: an entry stage, the azimuth and elevation cordic chains, then the decide registers
// throughput one point per cycle while the output is not stalled, the two cordic cell chains running in series
// a stalled output freezes every stage; input ready is high while the output is empty or being taken
// reset clears the stage valid bits and the configuration to its defaults
// uses lasm_pkg, lasm_point_if, lasm_mask_if, lasm_cordic_cell, lasm_decide
module lidar_angular_sector_mask #(
    parameter int MAX_SECTORS   = lasm_pkg::MAX_SECTORS_DEF,
    parameter int COORD_WIDTH   = lasm_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = lasm_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lasm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lasm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    lasm_point_if.sink                        i_point,
    lasm_mask_if.source                       o_mask
);
    import lasm_pkg::*;

    localparam int W     = COORD_WIDTH + 24;
    localparam int S     = CORDIC_STAGES;
    localparam int DEPTH = 2 * S + 3;
    localparam int ASW   = W + 3;
    localparam int ESW   = 32 + 3;

    logic               r_mask_enable;
    logic signed [16:0] r_elev_floor, r_elev_ceiling;
    logic [1:0]         r_sector_count;
    logic [1:0][15:0]   r_sec_lo, r_sec_hi;
    t_cfg               cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_enable  <= 1'b0;
            r_elev_floor   <= -17'sd63936;
            r_elev_ceiling <= 17'sd63936;
            r_sector_count <= 2'd0;
            r_sec_lo       <= '0;
            r_sec_hi       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MASK_ENABLE:  r_mask_enable  <= i_cfg_data[0];
                REG_ELEV_FLOOR:   r_elev_floor   <= i_cfg_data;
                REG_ELEV_CEILING: r_elev_ceiling <= i_cfg_data;
                REG_SECTOR_COUNT: r_sector_count <= i_cfg_data[1:0];
                REG_SECTOR0_LO:   r_sec_lo[0]    <= i_cfg_data[15:0];
                REG_SECTOR0_HI:   r_sec_hi[0]    <= i_cfg_data[15:0];
                REG_SECTOR1_LO:   r_sec_lo[1]    <= i_cfg_data[15:0];
                REG_SECTOR1_HI:   r_sec_hi[1]    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.enable   = r_mask_enable;
        cfg.floor_on = r_elev_floor > -17'sd57600;
        cfg.ceil_on  = r_elev_ceiling < 17'sd57600;
        cfg.floor_v  = r_elev_floor;
        cfg.ceil_v   = r_elev_ceiling;
        cfg.sec_used[0] = r_sector_count >= 2'd1;
        cfg.sec_used[1] = r_sector_count >= 2'd2;
        for (int k = 0; k < 2; k++) begin
            cfg.sec_lo[k] = norm_angle(r_sec_lo[k]);
            cfg.sec_hi[k] = norm_angle(r_sec_hi[k]);
        end
    end

    // stall control
    logic             en;
    logic [DEPTH-1:0] r_vld;

    assign en            = !o_mask.valid || o_mask.ready;
    assign i_point.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_point.valid};
        end
    end

    // entry stage: half-turn fold, z gain scaling, special-case flags
    logic signed [W-1:0]  x_sc, y_sc, n_cx, n_cy;
    logic signed [W-1:0]  r_cx, r_cy, r_zk;
    logic [31:0]          n_acc0, r_acc0;
    logic signed [COORD_WIDTH+21:0] zk_prod;
    t_flags               n_flags, r_flags;

    always_comb begin
        x_sc = W'(i_point.point_x) <<< FRAC_SHIFT;
        y_sc = W'(i_point.point_y) <<< FRAC_SHIFT;
        if (i_point.point_x[COORD_WIDTH-1]) begin
            n_cx   = -x_sc;
            n_cy   = -y_sc;
            n_acc0 = 32'h80000000;
        end else begin
            n_cx   = x_sc;
            n_cy   = y_sc;
            n_acc0 = '0;
        end
        zk_prod = (COORD_WIDTH+22)'(i_point.point_z) * (COORD_WIDTH+22)'(GAIN_Q20);
        n_flags.axis   = (i_point.point_x == '0) && (i_point.point_y == '0);
        n_flags.origin = n_flags.axis && (i_point.point_z == '0);
        n_flags.zpos   = !i_point.point_z[COORD_WIDTH-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_acc0  <= n_acc0;
            r_zk    <= W'(zk_prod);
            r_flags <= n_flags;
        end
    end

    // azimuth chain
    logic signed [W-1:0] ax [S+1];
    logic signed [W-1:0] ay [S+1];
    logic [31:0]         aacc [S+1];
    logic [ASW-1:0]      aside [S+1];

    assign ax[0]    = r_cx;
    assign ay[0]    = r_cy;
    assign aacc[0]  = r_acc0;
    assign aside[0] = {r_zk, r_flags};

    // elevation chain
    logic signed [W-1:0] ex [S+1];
    logic signed [W-1:0] ey [S+1];
    logic [31:0]         eacc [S+1];
    logic [ESW-1:0]      eside [S+1];

    assign ex[0]    = ax[S];
    assign ey[0]    = aside[S][ASW-1:3];
    assign eacc[0]  = '0;
    assign eside[0] = {aacc[S], aside[S][2:0]};

    for (genvar i = 0; i < S; i++) begin : g_cells
        lasm_cordic_cell #(.W(W), .SW(ASW), .SHIFT(i)) u_az (
            .i_clk(i_clk), .i_en(en),
            .i_x(ax[i]), .i_y(ay[i]), .i_acc(aacc[i]), .i_side(aside[i]),
            .o_x(ax[i+1]), .o_y(ay[i+1]), .o_acc(aacc[i+1]), .o_side(aside[i+1])
        );
        lasm_cordic_cell #(.W(W), .SW(ESW), .SHIFT(i)) u_el (
            .i_clk(i_clk), .i_en(en),
            .i_x(ex[i]), .i_y(ey[i]), .i_acc(eacc[i]), .i_side(eside[i]),
            .o_x(ex[i+1]), .o_y(ey[i+1]), .o_acc(eacc[i+1]), .o_side(eside[i+1])
        );
    end

    t_reason reason;
    logic    remove;

    lasm_decide #(.MAX_SECTORS(MAX_SECTORS)) u_decide (
        .i_clk(i_clk), .i_en(en),
        .i_az_acc(eside[S][ESW-1:3]), .i_el_acc(eacc[S]),
        .i_flags(t_flags'(eside[S][2:0])), .i_cfg(cfg),
        .o_remove(remove), .o_reason(reason)
    );

    assign o_mask.valid         = r_vld[DEPTH-1];
    assign o_mask.remove_point  = remove;
    assign o_mask.remove_reason = reason;

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_point.valid && i_point.ready) |=> r_vld[0])
        else $error("accepted point missing from first stage");

    a_disabled_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mask.valid && !r_mask_enable) |-> (reason == REASON_KEEP))
        else $error("point removed while mask disabled");

    a_ceiling_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mask.valid && reason == REASON_ABOVE) |-> cfg.ceil_on)
        else $error("ceiling reason with ceiling inactive");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved during stall");
endmodule
